// File: rtl/fhss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fhss_pkg
// Shared widths, codes, reset values and controller/datapath bundles for the
// frequency-hopping sequencer.
// ----------------------------------------------------------------------------
package fhss_pkg;

	localparam int MODE_W     = 2;
	localparam int BYTE_W     = 8;
	localparam int CHIDX_W    = 4;
	localparam int FREQ_W     = 21;
	localparam int DWELL_W    = 16;
	localparam int BASE_W     = 20;
	localparam int SPACING_W  = 14;
	localparam int RDV_W      = 4;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 20;

	typedef enum logic [MODE_W-1:0] {
		MODE_SEED = 2'd0,
		MODE_BYTE = 2'd1,
		MODE_TICK = 2'd2,
		MODE_SYNC = 2'd3
	} mode_t;

	localparam logic [CFG_IDX_W-1:0] REG_DWELL   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE    = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPACING = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RDV     = 4'd3;

	localparam logic [DWELL_W-1:0]   DWELL_RST   = 16'd50;
	localparam logic [BASE_W-1:0]    BASE_RST    = 20'd433050;
	localparam logic [SPACING_W-1:0] SPACING_RST = 14'd300;
	localparam logic [RDV_W-1:0]     RDV_RST     = 4'd0;

	localparam logic [FREQ_W-1:0]    FREQ_MAX    = 21'h1F_FFFF;

	typedef struct packed {
		logic cap;
		logic exec;
		logic mod_start;
		logic rd_swap;
		logic wr_top;
		logic wr_j;
		logic swap_done;
		logic rd_ch;
		logic sel_ch;
		logic load_out;
	} fhss_cmd_t;

	typedef struct packed {
		logic mode_byte;
		logic shuffle_go;
		logic mod_done;
		logic out_free;
	} fhss_stat_t;

endpackage
`default_nettype wire

// File: rtl/fhss_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fhss_if
// Valid/ready channels of the hop sequencer: input items, result items and
// configuration writes.
// ----------------------------------------------------------------------------
interface fhss_in_if import fhss_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [BYTE_W-1:0] random_byte;

	modport source (output valid, output mode, output random_byte, input ready);
	modport sink   (input valid, input mode, input random_byte, output ready);
endinterface

interface fhss_out_if import fhss_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CHIDX_W-1:0] channel_index;
	logic [FREQ_W-1:0]  frequency_khz;
	logic               hopped;
	logic               shuffle_pending;
	logic               is_synchronized;

	modport source (output valid, output channel_index, output frequency_khz,
		output hopped, output shuffle_pending, output is_synchronized, input ready);
	modport sink   (input valid, input channel_index, input frequency_khz,
		input hopped, input shuffle_pending, input is_synchronized, output ready);
endinterface

interface fhss_cfg_if import fhss_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/fhss_mod.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fhss_mod
// Restoring remainder unit: byte mod divisor, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module fhss_mod import fhss_pkg::*; #(
	parameter int CH_W = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [BYTE_W-1:0] dividend,
	input  logic [CH_W:0]     divisor,
	output logic              done,
	output logic [CH_W-1:0]   remainder
);

	localparam int              CNT_W = $clog2(BYTE_W);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(BYTE_W - 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [BYTE_W-1:0] num_q;
	logic [CH_W:0]     rem_q;
	logic [CH_W+1:0]   trial;
	logic [CH_W+1:0]   dvs_ext;
	logic [CH_W+1:0]   trial_sub;

	assign trial     = {rem_q, num_q[BYTE_W-1]};
	assign dvs_ext   = {1'b0, divisor};
	assign trial_sub = trial - dvs_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[BYTE_W-2:0], 1'b0};
			if (trial >= dvs_ext) begin
				rem_q <= trial_sub[CH_W:0];
			end else begin
				rem_q <= trial[CH_W:0];
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q[CH_W-1:0];

endmodule
`default_nettype wire

// File: rtl/fhss_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fhss_ctrl
// Sequencer for one item: apply the mode, run a shuffle swap when one is due,
// read the current channel and hand the result to the output register.
// ----------------------------------------------------------------------------
module fhss_ctrl import fhss_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  fhss_stat_t stat,
	output fhss_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_MOD,
		S_RD,
		S_WR_TOP,
		S_WR_J,
		S_CH_RD,
		S_SEL,
		S_OUT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (stat.mode_byte && stat.shuffle_go) state_q <= S_MOD;
					else state_q <= S_CH_RD;
				end
				S_MOD: begin
					if (stat.mod_done) state_q <= S_RD;
				end
				S_RD:     state_q <= S_WR_TOP;
				S_WR_TOP: state_q <= S_WR_J;
				S_WR_J:   state_q <= S_CH_RD;
				S_CH_RD:  state_q <= S_SEL;
				S_SEL:    state_q <= S_OUT;
				S_OUT: begin
					if (stat.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: cmd.cap = in_valid;
			S_EXEC: begin
				if (stat.mode_byte && stat.shuffle_go) cmd.mod_start = 1'b1;
				else cmd.exec = 1'b1;
			end
			S_MOD:    ;
			S_RD:     cmd.rd_swap = 1'b1;
			S_WR_TOP: cmd.wr_top = 1'b1;
			S_WR_J: begin
				cmd.wr_j      = 1'b1;
				cmd.swap_done = 1'b1;
			end
			S_CH_RD:  cmd.rd_ch = 1'b1;
			S_SEL:    cmd.sel_ch = 1'b1;
			S_OUT:    cmd.load_out = stat.out_free;
			default:  ;
		endcase
	end

endmodule
`default_nettype wire

// File: rtl/fhss_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fhss_dp
// Datapath: configuration registers, hop state, permutation memory with
// per-entry valid bits, remainder unit, frequency multiply-add and result
// register.
// ----------------------------------------------------------------------------
module fhss_dp import fhss_pkg::*; #(
	parameter int NUM_CHANNELS = 15
) (
	input  logic              clk,
	input  logic              arst_n,
	input  fhss_cmd_t         cmd,
	output fhss_stat_t        stat,
	input  logic [MODE_W-1:0] in_mode,
	input  logic [BYTE_W-1:0] in_byte,
	fhss_cfg_if.sink          cfg,
	fhss_out_if.source        item_out
);

	localparam int CH_W   = $clog2(NUM_CHANNELS);
	localparam int CV_W   = (CH_W > RDV_W) ? CH_W : RDV_W;
	localparam int PROD_W = CV_W + SPACING_W;
	localparam int SUM_W  = ((PROD_W > BASE_W) ? PROD_W : BASE_W) + 1;
	localparam logic [CH_W-1:0] TOP_IDX = CH_W'(NUM_CHANNELS - 1);

	// configuration
	logic [DWELL_W-1:0]   dwell_q;
	logic [BASE_W-1:0]    base_q;
	logic [SPACING_W-1:0] spacing_q;
	logic [RDV_W-1:0]     rdv_q;

	// hop state
	logic [MODE_W-1:0]  mode_q;
	logic [BYTE_W-1:0]  byte_q;
	logic [CH_W-1:0]    slot_q;
	logic [CH_W-1:0]    sidx_q;
	logic               pending_q;
	logic               seeded_q;
	logic               sync_q;
	logic [DWELL_W-1:0] elapsed_q;
	logic               hop_owed_q;
	logic               hopped_q;
	logic [CV_W-1:0]    held_q;

	// permutation memory
	logic [CH_W-1:0]         mem [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] vld_q;
	logic [CH_W-1:0]         rda_data_q, rda_addr_q, rdb_data_q, rdb_addr_q;
	logic                    rda_vld_q, rdb_vld_q;
	logic [CH_W-1:0]         rda_addr, rda_val, rdb_val;
	logic                    mem_we;
	logic [CH_W-1:0]         mem_wa, mem_wd;

	logic [CH_W:0]      divisor;
	logic               mod_done;
	logic [CH_W-1:0]    swap_j;
	logic [DWELL_W-1:0] elapsed_inc;
	logic               dwell_hit;
	logic               last_slot;
	logic               tick_go;
	logic               begin_sh;
	logic [CV_W-1:0]    ch_sel;
	logic [PROD_W-1:0]  prod_q;
	logic [SUM_W-1:0]   freq_sum;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dwell_q   <= DWELL_RST;
			base_q    <= BASE_RST;
			spacing_q <= SPACING_RST;
			rdv_q     <= RDV_RST;
		end else if (cfg.valid) begin
			if (cfg.index == REG_DWELL)   dwell_q   <= cfg.data[DWELL_W-1:0];
			if (cfg.index == REG_BASE)    base_q    <= cfg.data[BASE_W-1:0];
			if (cfg.index == REG_SPACING) spacing_q <= cfg.data[SPACING_W-1:0];
			if (cfg.index == REG_RDV)     rdv_q     <= cfg.data[RDV_W-1:0];
		end
	end

	assign divisor = {1'b0, sidx_q} + (CH_W+1)'(1);

	fhss_mod #(.CH_W(CH_W)) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.mod_start),
		.dividend  (byte_q),
		.divisor   (divisor),
		.done      (mod_done),
		.remainder (swap_j)
	);

	assign elapsed_inc = (elapsed_q != '1) ? elapsed_q + 1'b1 : elapsed_q;
	assign dwell_hit   = (elapsed_inc >= dwell_q);
	assign last_slot   = (slot_q == TOP_IDX);
	assign tick_go     = (mode_t'(mode_q) == MODE_TICK) && sync_q && !pending_q;
	assign begin_sh    = cmd.exec && (((mode_t'(mode_q) == MODE_SEED) && !seeded_q)
		|| (tick_go && dwell_hit && last_slot));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= '0;
			byte_q     <= '0;
			slot_q     <= '0;
			sidx_q     <= '0;
			pending_q  <= 1'b0;
			seeded_q   <= 1'b0;
			sync_q     <= 1'b0;
			elapsed_q  <= '0;
			hop_owed_q <= 1'b0;
			hopped_q   <= 1'b0;
			held_q     <= '0;
		end else begin
			if (cmd.cap) begin
				mode_q   <= in_mode;
				byte_q   <= in_byte;
				hopped_q <= 1'b0;
			end
			if (cmd.exec) begin
				unique case (mode_t'(mode_q))
					MODE_SEED: begin
						if (!seeded_q) begin
							seeded_q   <= 1'b1;
							hop_owed_q <= 1'b0;
						end
					end
					MODE_BYTE: ;
					MODE_TICK: begin
						if (tick_go) begin
							if (dwell_hit) begin
								elapsed_q <= '0;
								if (last_slot) begin
									hop_owed_q <= 1'b1;
								end else begin
									slot_q   <= slot_q + 1'b1;
									hopped_q <= 1'b1;
								end
							end else begin
								elapsed_q <= elapsed_inc;
							end
						end
					end
					MODE_SYNC: begin
						if (seeded_q) begin
							sync_q    <= 1'b1;
							elapsed_q <= '0;
						end
					end
					default: ;
				endcase
			end
			if (begin_sh) begin
				slot_q    <= '0;
				sidx_q    <= TOP_IDX;
				pending_q <= 1'b1;
			end
			if (cmd.swap_done) begin
				sidx_q <= sidx_q - 1'b1;
				if (sidx_q == CH_W'(1)) begin
					pending_q <= 1'b0;
					if (hop_owed_q) begin
						hopped_q   <= 1'b1;
						hop_owed_q <= 1'b0;
					end
				end
			end
			if (cmd.sel_ch) held_q <= ch_sel;
		end
	end

	// entries not written since the last shuffle start read as identity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (begin_sh) begin
			vld_q <= '0;
		end else if (mem_we) begin
			vld_q[mem_wa] <= 1'b1;
		end
	end

	assign rda_addr = cmd.rd_ch ? slot_q : sidx_q;
	assign rda_val  = rda_vld_q ? rda_data_q : rda_addr_q;
	assign rdb_val  = rdb_vld_q ? rdb_data_q : rdb_addr_q;
	assign mem_we   = cmd.wr_top || cmd.wr_j;
	assign mem_wa   = cmd.wr_top ? sidx_q : swap_j;
	assign mem_wd   = cmd.wr_top ? rdb_val : rda_val;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (cmd.rd_swap || cmd.rd_ch) begin
			rda_data_q <= mem[rda_addr];
			rda_vld_q  <= vld_q[rda_addr];
			rda_addr_q <= rda_addr;
		end
		if (cmd.rd_swap) begin
			rdb_data_q <= mem[swap_j];
			rdb_vld_q  <= vld_q[swap_j];
			rdb_addr_q <= swap_j;
		end
	end

	always_comb begin
		priority if (!sync_q) ch_sel = CV_W'(rdv_q);
		else if (pending_q)  ch_sel = held_q;
		else                 ch_sel = CV_W'(rda_val);
	end

	always_ff @(posedge clk) begin
		if (cmd.sel_ch) prod_q <= PROD_W'(ch_sel) * PROD_W'(spacing_q);
	end

	assign freq_sum = SUM_W'(base_q) + SUM_W'(prod_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_out.valid <= 1'b0;
		end else if (cmd.load_out) begin
			item_out.valid <= 1'b1;
		end else if (item_out.ready) begin
			item_out.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			item_out.channel_index   <= held_q[CHIDX_W-1:0];
			item_out.frequency_khz   <= (freq_sum > SUM_W'(FREQ_MAX)) ? FREQ_MAX
				: freq_sum[FREQ_W-1:0];
			item_out.hopped          <= hopped_q;
			item_out.shuffle_pending <= pending_q;
			item_out.is_synchronized <= sync_q;
		end
	end

	assign stat.mode_byte  = (mode_t'(mode_q) == MODE_BYTE);
	assign stat.shuffle_go = pending_q && (sidx_q != '0);
	assign stat.mod_done   = mod_done;
	assign stat.out_free   = !item_out.valid || item_out.ready;

endmodule
`default_nettype wire

// File: rtl/fhss_hop_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fhss_hop_sequencer
// Frequency-hopping sequencer with a shuffled channel table.
//
// item_in carries mode and random_byte; every accepted item produces exactly
// one item on item_out (channel, frequency in kHz and status flags). cfg is a
// write channel for dwell, base frequency, spacing and rendezvous channel; it
// is always ready and is meant to be written while the block is idle.
// Items are processed one at a time: the next item is taken only once the
// previous result has been loaded into the output register. A seed, tick,
// sync or idle random byte passes through the execute, channel read, select
// and output states. A random byte that performs a shuffle swap first waits
// on the bit-serial remainder unit, then does a read and two writes on the
// single write port of the permutation memory before the channel read.
// The result waits in an output register; a stalled receiver holds it there
// and the block stalls only when the next result is ready to be loaded.
// Reset restores the default configuration, identity channel order and the
// unsynchronized state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module fhss_hop_sequencer import fhss_pkg::*; #(
	parameter int NUM_CHANNELS = 15
) (
	input  logic       clk,
	input  logic       arst_n,
	fhss_in_if.sink    item_in,
	fhss_out_if.source item_out,
	fhss_cfg_if.sink   cfg
);

	fhss_cmd_t  cmd;
	fhss_stat_t stat;
	logic       in_ready;

	assign item_in.ready = in_ready;

	fhss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item_in.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	fhss_dp #(.NUM_CHANNELS(NUM_CHANNELS)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.in_mode  (item_in.mode),
		.in_byte  (item_in.random_byte),
		.cfg      (cfg),
		.item_out (item_out)
	);

endmodule
`default_nettype wire
